[hw/rtl/priority_inheritance_mutex_engine_unit_macros.svh]
// assertion macros for the mutex engine
`ifndef PRIORITY_INHERITANCE_MUTEX_ENGINE_UNIT_MACROS_SVH
`define PRIORITY_INHERITANCE_MUTEX_ENGINE_UNIT_MACROS_SVH
`define PIM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PIM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hw/rtl/pim_pkg.sv]
// package: codes, states and defaults of the mutex engine
package pim_pkg;
    localparam int NUM_MUTEXES_DEF = 8;
    localparam int NUM_TASKS_DEF = 16;
    localparam int WAIT_DEPTH_DEF = 16;

    localparam logic [2:0] KIND_CREATE = 3'd0;
    localparam logic [2:0] KIND_DELETE = 3'd1;
    localparam logic [2:0] KIND_LOCK = 3'd2;
    localparam logic [2:0] KIND_UNLOCK = 3'd3;
    localparam logic [2:0] KIND_QUERY = 3'd4;

    localparam logic [3:0] ST_OK = 4'd0;
    localparam logic [3:0] ST_UNAVAIL = 4'd1;
    localparam logic [3:0] ST_NO_SLOT = 4'd2;
    localparam logic [3:0] ST_ISR = 4'd3;
    localparam logic [3:0] ST_WOULD_BLOCK = 4'd4;
    localparam logic [3:0] ST_NOT_OWNER = 4'd5;
    localparam logic [3:0] ST_QUEUED = 4'd6;
    localparam logic [3:0] ST_WAIT_FULL = 4'd7;
    localparam logic [3:0] ST_COUNT_FULL = 4'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_WAKE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic       hit;
        logic       free;
    } scan_ctl_t;
endpackage

[hw/rtl/pim_scan.sv]
// scanner: walks the slot ids one per cycle looking for a match or a free slot
module pim_scan #(
    parameter int NUM_MUTEXES = pim_pkg::NUM_MUTEXES_DEF,
    localparam int SW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [31:0]   key,
    input  logic [31:0]   cur_id,
    output logic [SW-1:0] idx,
    output logic          last,
    output pim_pkg::scan_ctl_t ctl
);
    logic [SW-1:0] idx_reg, idx_next;
    logic          hit_reg, hit_next, free_reg, free_next;
    logic [SW-1:0] hidx_reg, hidx_next, fidx_reg, fidx_next;
    logic          act_reg, act_next;

    assign last = act_reg && (idx_reg == SW'(NUM_MUTEXES - 1));

    always_comb
    begin
        idx_next = idx_reg;
        hit_next = hit_reg;
        free_next = free_reg;
        hidx_next = hidx_reg;
        fidx_next = fidx_reg;
        act_next = act_reg;
        if (go)
        begin
            idx_next = '0;
            hit_next = 1'b0;
            free_next = 1'b0;
            act_next = 1'b1;
        end
        else if (act_reg)
        begin
            if (!hit_reg && key != 32'd0 && cur_id == key)
            begin
                hit_next = 1'b1;
                hidx_next = idx_reg;
            end
            if (!free_reg && cur_id == 32'd0)
            begin
                free_next = 1'b1;
                fidx_next = idx_reg;
            end
            if (last)
                act_next = 1'b0;
            else
                idx_next = idx_reg + SW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            hit_reg <= 1'b0;
            free_reg <= 1'b0;
            act_reg <= 1'b0;
            hidx_reg <= '0;
            fidx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            hit_reg <= hit_next;
            free_reg <= free_next;
            act_reg <= act_next;
            hidx_reg <= hidx_next;
            fidx_reg <= fidx_next;
        end
    end

    always_comb
    begin
        ctl.hit = hit_reg;
        ctl.free = free_reg;
    end

    assign idx = act_reg ? idx_reg : (hit_reg ? hidx_reg : fidx_reg);
endmodule

[hw/rtl/priority_inheritance_mutex_engine_unit.sv]
// top level: priority inheritance mutex engine
// usage: pulse start with the request fields while busy is low; the request
// is taken at that edge and busy rises. the slot table is searched one slot
// a cycle through a shared id comparator, then the slot is updated and, on a
// hand-over, the head of the wait queue is read for an extra wake state.
// sequence: scan, exec, then a wake state for an unlock that hands over to a
// waiter, then the result beat in the done state. busy drops after the beat,
// so a new request is taken only once the last one is through.
// result: done is high for one cycle with status and the other result ports;
// the receiver cannot stall and must take the beat in that cycle.
// config: cfg_valid/cfg_ready write kernel_ready; cfg_ready is always high.
// reset: all slots free, no locks, id counter and priority table zero,
// kernel_ready 0. the wait queue memory needs no clearing since only entries
// inside a queue are read.
// the comparator loop over slots sets the latency.
module priority_inheritance_mutex_engine_unit #(
    parameter int NUM_MUTEXES = pim_pkg::NUM_MUTEXES_DEF,
    parameter int NUM_TASKS = pim_pkg::NUM_TASKS_DEF,
    parameter int WAIT_DEPTH = pim_pkg::WAIT_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic [2:0]  kind,
    input  logic [31:0] mutex_ref,
    input  logic [3:0]  task_req,
    input  logic        task_valid,
    input  logic [7:0]  task_priority,
    input  logic        may_wait,
    input  logic        in_isr,
    output logic        done,
    output logic [3:0]  status,
    output logic [31:0] new_id,
    output logic        owned,
    output logic        prio_valid,
    output logic [3:0]  prio_task,
    output logic [7:0]  prio_value,
    output logic        wake_valid,
    output logic [3:0]  woken_task,
    output logic        block_caller
);
    `include "priority_inheritance_mutex_engine_unit_macros.svh"

    localparam int SW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
    localparam int TW = $clog2(NUM_TASKS);
    localparam int QW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int FW = $clog2(WAIT_DEPTH + 1);
    localparam int MD = NUM_MUTEXES * WAIT_DEPTH;
    localparam int MW = (MD > 1) ? $clog2(MD) : 1;

    pim_pkg::state_t state_reg, state_next;
    logic kready_reg;

    logic [31:0]   slot_id_reg [NUM_MUTEXES];
    logic          slot_locked_reg [NUM_MUTEXES];
    logic [TW-1:0] slot_owner_reg [NUM_MUTEXES];
    logic [7:0]    slot_count_reg [NUM_MUTEXES];
    logic [7:0]    slot_saved_reg [NUM_MUTEXES];
    logic [QW-1:0] wait_head_reg [NUM_MUTEXES];
    logic [FW-1:0] wait_fill_reg [NUM_MUTEXES];
    logic [7:0]    prio_reg [NUM_TASKS];
    logic [31:0]   id_counter_reg;
    logic [TW-1:0] wait_mem [MD];
    logic [TW-1:0] wrd_reg;

    logic [2:0]    kind_reg;
    logic [31:0]   mid_reg;
    logic [TW-1:0] task_reg;
    logic          tv_reg, mw_reg, isr_reg;

    logic [SW-1:0] sidx;
    logic          slast;
    pim_pkg::scan_ctl_t sctl;
    logic          go;
    logic [31:0]   scan_key;

    logic [3:0]  status_reg;
    logic [31:0] new_id_reg;
    logic owned_reg, pv_reg, wv_reg, blk_reg;
    logic [TW-1:0] pt_reg, wt_reg;
    logic [7:0] pval_reg;

    logic [31:0] cnt_inc;
    logic [31:0] qpos_sum;
    logic [QW-1:0] qpos, head_inc;
    logic [MW-1:0] waddr, raddr;
    logic wr_en;

    assign go = start && !busy;
    assign cfg_ready = 1'b1;
    assign busy = state_reg != pim_pkg::S_IDLE;

    // create looks for a free slot only
    assign scan_key = (kind_reg == pim_pkg::KIND_CREATE) ? 32'd0 : mid_reg;

    pim_scan #(.NUM_MUTEXES(NUM_MUTEXES)) u_scan (
        .clk(clk), .rst_n(rst_n), .go(go), .key(scan_key),
        .cur_id(slot_id_reg[sidx]), .idx(sidx), .last(slast), .ctl(sctl)
    );

    assign cnt_inc = (id_counter_reg + 32'd1 == 32'd0) ? 32'd1 : id_counter_reg + 32'd1;
    assign qpos_sum = 32'(wait_head_reg[sidx]) + 32'(wait_fill_reg[sidx]);
    assign qpos = (qpos_sum >= 32'(WAIT_DEPTH)) ? QW'(qpos_sum - 32'(WAIT_DEPTH))
                                                : QW'(qpos_sum);
    assign head_inc = (32'(wait_head_reg[sidx]) + 32'd1 >= 32'(WAIT_DEPTH)) ? '0
                                                : wait_head_reg[sidx] + QW'(1);
    assign waddr = MW'(sidx * WAIT_DEPTH) + MW'(qpos);
    assign raddr = MW'(sidx * WAIT_DEPTH) + MW'(wait_head_reg[sidx]);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            wait_mem[waddr] <= task_reg;
        wrd_reg <= wait_mem[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pim_pkg::S_IDLE: if (go) state_next = pim_pkg::S_SCAN;
            pim_pkg::S_SCAN: if (slast) state_next = pim_pkg::S_EXEC;
            pim_pkg::S_EXEC:
                if (kind_reg == pim_pkg::KIND_UNLOCK && sctl.hit && tv_reg
                    && slot_locked_reg[sidx] && slot_owner_reg[sidx] == task_reg
                    && slot_count_reg[sidx] <= 8'd1 && wait_fill_reg[sidx] != '0)
                    state_next = pim_pkg::S_WAKE;
                else
                    state_next = pim_pkg::S_DONE;
            pim_pkg::S_WAKE: state_next = pim_pkg::S_DONE;
            pim_pkg::S_DONE: state_next = pim_pkg::S_IDLE;
            default: state_next = pim_pkg::S_IDLE;
        endcase
    end

    assign wr_en = state_reg == pim_pkg::S_EXEC && kind_reg == pim_pkg::KIND_LOCK
        && !isr_reg && sctl.hit && tv_reg && slot_locked_reg[sidx]
        && slot_owner_reg[sidx] != task_reg && mw_reg
        && wait_fill_reg[sidx] < FW'(WAIT_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pim_pkg::S_IDLE;
            kready_reg <= 1'b0;
            id_counter_reg <= '0;
            for (int i = 0; i < NUM_MUTEXES; i++)
            begin
                slot_id_reg[i] <= '0;
                slot_locked_reg[i] <= 1'b0;
                slot_owner_reg[i] <= '0;
                slot_count_reg[i] <= '0;
                slot_saved_reg[i] <= '0;
                wait_head_reg[i] <= '0;
                wait_fill_reg[i] <= '0;
            end
            for (int t = 0; t < NUM_TASKS; t++)
                prio_reg[t] <= '0;
            kind_reg <= '0;
            mid_reg <= '0;
            task_reg <= '0;
            tv_reg <= 1'b0;
            mw_reg <= 1'b0;
            isr_reg <= 1'b0;
            status_reg <= '0;
            new_id_reg <= '0;
            owned_reg <= 1'b0;
            pv_reg <= 1'b0;
            pt_reg <= '0;
            pval_reg <= '0;
            wv_reg <= 1'b0;
            wt_reg <= '0;
            blk_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                kready_reg <= cfg_data;
            if (go)
            begin
                kind_reg <= kind;
                mid_reg <= mutex_ref;
                task_reg <= TW'(task_req);
                tv_reg <= task_valid;
                mw_reg <= may_wait;
                isr_reg <= in_isr;
                if (task_valid)
                    prio_reg[TW'(task_req)] <= task_priority;
                status_reg <= pim_pkg::ST_OK;
                new_id_reg <= '0;
                owned_reg <= 1'b0;
                pv_reg <= 1'b0;
                pt_reg <= '0;
                pval_reg <= '0;
                wv_reg <= 1'b0;
                wt_reg <= '0;
                blk_reg <= 1'b0;
            end
            if (state_reg == pim_pkg::S_EXEC)
            begin
                priority case (kind_reg)
                    pim_pkg::KIND_CREATE:
                        if (!kready_reg)
                            status_reg <= pim_pkg::ST_UNAVAIL;
                        else if (!sctl.free)
                            status_reg <= pim_pkg::ST_NO_SLOT;
                        else
                        begin
                            id_counter_reg <= cnt_inc;
                            slot_id_reg[sidx] <= cnt_inc;
                            slot_locked_reg[sidx] <= 1'b0;
                            slot_owner_reg[sidx] <= '0;
                            slot_count_reg[sidx] <= '0;
                            slot_saved_reg[sidx] <= '0;
                            wait_head_reg[sidx] <= '0;
                            wait_fill_reg[sidx] <= '0;
                            new_id_reg <= cnt_inc;
                        end
                    pim_pkg::KIND_DELETE:
                        if (!sctl.hit)
                            status_reg <= pim_pkg::ST_UNAVAIL;
                        else
                        begin
                            slot_id_reg[sidx] <= '0;
                            slot_locked_reg[sidx] <= 1'b0;
                            slot_owner_reg[sidx] <= '0;
                            slot_count_reg[sidx] <= '0;
                            slot_saved_reg[sidx] <= '0;
                            wait_head_reg[sidx] <= '0;
                            wait_fill_reg[sidx] <= '0;
                        end
                    pim_pkg::KIND_LOCK:
                        if (isr_reg)
                            status_reg <= pim_pkg::ST_ISR;
                        else if (!sctl.hit || !tv_reg)
                            status_reg <= pim_pkg::ST_UNAVAIL;
                        else if (slot_locked_reg[sidx] && slot_owner_reg[sidx] == task_reg)
                        begin
                            if (slot_count_reg[sidx] == 8'd255)
                                status_reg <= pim_pkg::ST_COUNT_FULL;
                            else
                                slot_count_reg[sidx] <= slot_count_reg[sidx] + 8'd1;
                        end
                        else if (!slot_locked_reg[sidx])
                        begin
                            slot_locked_reg[sidx] <= 1'b1;
                            slot_owner_reg[sidx] <= task_reg;
                            slot_count_reg[sidx] <= 8'd1;
                            slot_saved_reg[sidx] <= prio_reg[task_reg];
                        end
                        else if (!mw_reg)
                            status_reg <= pim_pkg::ST_WOULD_BLOCK;
                        else if (!wr_en)
                            status_reg <= pim_pkg::ST_WAIT_FULL;
                        else
                        begin
                            if (prio_reg[task_reg] > prio_reg[slot_owner_reg[sidx]])
                            begin
                                prio_reg[slot_owner_reg[sidx]] <= prio_reg[task_reg];
                                pv_reg <= 1'b1;
                                pt_reg <= slot_owner_reg[sidx];
                                pval_reg <= prio_reg[task_reg];
                            end
                            wait_fill_reg[sidx] <= wait_fill_reg[sidx] + FW'(1);
                            status_reg <= pim_pkg::ST_QUEUED;
                            blk_reg <= 1'b1;
                        end
                    pim_pkg::KIND_UNLOCK:
                        if (!sctl.hit)
                            status_reg <= pim_pkg::ST_UNAVAIL;
                        else if (!tv_reg || !slot_locked_reg[sidx]
                                 || slot_owner_reg[sidx] != task_reg)
                            status_reg <= pim_pkg::ST_NOT_OWNER;
                        else if (slot_count_reg[sidx] > 8'd1)
                            slot_count_reg[sidx] <= slot_count_reg[sidx] - 8'd1;
                        else
                        begin
                            prio_reg[task_reg] <= slot_saved_reg[sidx];
                            pv_reg <= 1'b1;
                            pt_reg <= task_reg;
                            pval_reg <= slot_saved_reg[sidx];
                            if (wait_fill_reg[sidx] == '0)
                            begin
                                slot_locked_reg[sidx] <= 1'b0;
                                slot_owner_reg[sidx] <= '0;
                                slot_count_reg[sidx] <= '0;
                            end
                        end
                    pim_pkg::KIND_QUERY:
                        owned_reg <= sctl.hit && slot_locked_reg[sidx];
                    default:
                        status_reg <= pim_pkg::ST_UNAVAIL;
                endcase
            end
            if (state_reg == pim_pkg::S_WAKE)
            begin
                wait_head_reg[sidx] <= head_inc;
                wait_fill_reg[sidx] <= wait_fill_reg[sidx] - FW'(1);
                slot_owner_reg[sidx] <= wrd_reg;
                slot_count_reg[sidx] <= 8'd1;
                slot_saved_reg[sidx] <= prio_reg[wrd_reg];
                wv_reg <= 1'b1;
                wt_reg <= wrd_reg;
            end
        end
    end

    assign done = state_reg == pim_pkg::S_DONE;
    assign status = status_reg;
    assign new_id = new_id_reg;
    assign owned = owned_reg;
    assign prio_valid = pv_reg;
    assign prio_task = 4'(pt_reg);
    assign prio_value = pval_reg;
    assign wake_valid = wv_reg;
    assign woken_task = 4'(wt_reg);
    assign block_caller = blk_reg;

    `PIM_ASSERT_IMP(a_busy_on_start, go, state_next == pim_pkg::S_SCAN)
    `PIM_ASSERT_NEXT(a_done_idle, done, !busy)
    `PIM_ASSERT_IMP(a_block_queued, done && block_caller, status == pim_pkg::ST_QUEUED)
    `PIM_ASSERT_IMP(a_wake_prio, done && wake_valid, prio_valid && status == pim_pkg::ST_OK)
endmodule

[bench/testbench.sv]
// testbench for the priority inheritance mutex engine: directed table, bursts, random requests
`timescale 1ns / 1ps

module testbench;
    localparam int NM = pim_pkg::NUM_MUTEXES_DEF;
    localparam int NT = pim_pkg::NUM_TASKS_DEF;
    localparam int WD = pim_pkg::WAIT_DEPTH_DEF;
    localparam int LAT = NM + 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [2:0] KIND_BAD_LO = 3'd5;
    localparam logic [2:0] KIND_BAD_HI = 3'd7;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] mutex_ref;
        logic [3:0]  task_req;
        logic        task_valid;
        logic [7:0]  task_priority;
        logic        may_wait;
        logic        in_isr;
    } req_t;

    typedef struct {
        logic [3:0]  status;
        logic [31:0] new_id;
        logic        owned;
        logic        prio_valid;
        logic [3:0]  prio_task;
        logic [7:0]  prio_value;
        logic        wake_valid;
        logic [3:0]  woken_task;
        logic        block_caller;
    } res_t;

    typedef struct {
        req_t       rq;
        logic       typed;
        logic [3:0] st;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic [2:0]  kind;
    logic [31:0] mutex_ref;
    logic [3:0]  task_req;
    logic        task_valid;
    logic [7:0]  task_priority;
    logic        may_wait;
    logic        in_isr;
    logic        done;
    logic [3:0]  status;
    logic [31:0] new_id;
    logic        owned;
    logic        prio_valid;
    logic [3:0]  prio_task;
    logic [7:0]  prio_value;
    logic        wake_valid;
    logic [3:0]  woken_task;
    logic        block_caller;

    priority_inheritance_mutex_engine_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .kind(kind), .mutex_ref(mutex_ref), .task_req(task_req), .task_valid(task_valid),
        .task_priority(task_priority), .may_wait(may_wait), .in_isr(in_isr),
        .done(done), .status(status), .new_id(new_id), .owned(owned),
        .prio_valid(prio_valid), .prio_task(prio_task), .prio_value(prio_value),
        .wake_valid(wake_valid), .woken_task(woken_task), .block_caller(block_caller)
    );

    // mirror of the mutex table
    logic [31:0] mtx_id [NM];
    logic        mtx_locked [NM];
    logic [3:0]  mtx_owner [NM];
    logic [7:0]  mtx_depth [NM];
    logic [7:0]  mtx_saved [NM];
    logic [3:0]  waiters [NM][WD];
    int          q_head [NM];
    int          q_fill [NM];
    logic [31:0] id_ctr;
    logic [7:0]  prio_tab [NT];
    logic        ready_reg;

    res_t outcome_q[$];
    int   errors;
    int   items_sent;
    int   results_seen;
    int   queued_seen;
    int   wakes_seen;
    int   idle_cycles;
    logic no_idle;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = 1'b1;
            #2 clk = 1'b0;
        end
    end

    function automatic int slot_of(logic [31:0] id);
        if (id == 32'd0)
            return -1;
        for (int i = 0; i < NM; i++)
            if (mtx_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void free_slot(int s);
        mtx_id[s] = '0;
        mtx_locked[s] = 1'b0;
        mtx_owner[s] = '0;
        mtx_depth[s] = '0;
        mtx_saved[s] = '0;
        q_head[s] = 0;
        q_fill[s] = 0;
    endfunction

    function automatic res_t apply_request(req_t r);
        res_t o;
        int s;
        int w;
        o = '{default: '0};
        if (r.task_valid)
            prio_tab[r.task_req] = r.task_priority;
        case (r.kind)
            pim_pkg::KIND_CREATE:
            begin
                s = -1;
                for (int i = NM - 1; i >= 0; i--)
                    if (mtx_id[i] == 32'd0)
                        s = i;
                if (!ready_reg)
                    o.status = pim_pkg::ST_UNAVAIL;
                else if (s < 0)
                    o.status = pim_pkg::ST_NO_SLOT;
                else
                begin
                    id_ctr = id_ctr + 32'd1;
                    if (id_ctr == 32'd0)
                        id_ctr = 32'd1;
                    free_slot(s);
                    mtx_id[s] = id_ctr;
                    o.new_id = id_ctr;
                end
            end
            pim_pkg::KIND_DELETE:
            begin
                s = slot_of(r.mutex_ref);
                if (s < 0)
                    o.status = pim_pkg::ST_UNAVAIL;
                else
                    free_slot(s);
            end
            pim_pkg::KIND_LOCK:
            begin
                s = slot_of(r.mutex_ref);
                if (r.in_isr)
                    o.status = pim_pkg::ST_ISR;
                else if (s < 0 || !r.task_valid)
                    o.status = pim_pkg::ST_UNAVAIL;
                else if (mtx_locked[s] && mtx_owner[s] == r.task_req)
                begin
                    if (mtx_depth[s] == 8'd255)
                        o.status = pim_pkg::ST_COUNT_FULL;
                    else
                        mtx_depth[s]++;
                end
                else if (!mtx_locked[s])
                begin
                    mtx_locked[s] = 1'b1;
                    mtx_owner[s] = r.task_req;
                    mtx_depth[s] = 8'd1;
                    mtx_saved[s] = prio_tab[r.task_req];
                end
                else if (!r.may_wait)
                    o.status = pim_pkg::ST_WOULD_BLOCK;
                else if (q_fill[s] >= WD)
                    o.status = pim_pkg::ST_WAIT_FULL;
                else
                begin
                    if (prio_tab[r.task_req] > prio_tab[mtx_owner[s]])
                    begin
                        prio_tab[mtx_owner[s]] = prio_tab[r.task_req];
                        o.prio_valid = 1'b1;
                        o.prio_task = mtx_owner[s];
                        o.prio_value = prio_tab[r.task_req];
                    end
                    waiters[s][(q_head[s] + q_fill[s]) % WD] = r.task_req;
                    q_fill[s]++;
                    o.status = pim_pkg::ST_QUEUED;
                    o.block_caller = 1'b1;
                end
            end
            pim_pkg::KIND_UNLOCK:
            begin
                s = slot_of(r.mutex_ref);
                if (s < 0)
                    o.status = pim_pkg::ST_UNAVAIL;
                else if (!r.task_valid || !mtx_locked[s] || mtx_owner[s] != r.task_req)
                    o.status = pim_pkg::ST_NOT_OWNER;
                else if (mtx_depth[s] > 8'd1)
                    mtx_depth[s]--;
                else
                begin
                    prio_tab[r.task_req] = mtx_saved[s];
                    o.prio_valid = 1'b1;
                    o.prio_task = r.task_req;
                    o.prio_value = mtx_saved[s];
                    if (q_fill[s] > 0)
                    begin
                        w = waiters[s][q_head[s]];
                        q_head[s] = (q_head[s] + 1) % WD;
                        q_fill[s]--;
                        mtx_owner[s] = w[3:0];
                        mtx_depth[s] = 8'd1;
                        mtx_saved[s] = prio_tab[w];
                        o.wake_valid = 1'b1;
                        o.woken_task = w[3:0];
                    end
                    else
                    begin
                        mtx_locked[s] = 1'b0;
                        mtx_owner[s] = '0;
                        mtx_depth[s] = '0;
                    end
                end
            end
            pim_pkg::KIND_QUERY:
            begin
                s = slot_of(r.mutex_ref);
                o.owned = (s >= 0) && mtx_locked[s];
            end
            default:
                o.status = pim_pkg::ST_UNAVAIL;
        endcase
        return o;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s at %0t: got %0h, expected %0h", field, $realtime, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && done)
        begin
            results_seen++;
            if (outcome_q.size() == 0)
                report("unexpected beat", 32'd1, 32'd0);
            else
            begin
                e = outcome_q.pop_front();
                if (status !== e.status) report("status", 32'(status), 32'(e.status));
                if (new_id !== e.new_id) report("new_id", new_id, e.new_id);
                if (owned !== e.owned) report("owned", 32'(owned), 32'(e.owned));
                if (prio_valid !== e.prio_valid)
                    report("prio_valid", 32'(prio_valid), 32'(e.prio_valid));
                if (prio_task !== e.prio_task)
                    report("prio_task", 32'(prio_task), 32'(e.prio_task));
                if (prio_value !== e.prio_value)
                    report("prio_value", 32'(prio_value), 32'(e.prio_value));
                if (wake_valid !== e.wake_valid)
                    report("wake_valid", 32'(wake_valid), 32'(e.wake_valid));
                if (woken_task !== e.woken_task)
                    report("woken_task", 32'(woken_task), 32'(e.woken_task));
                if (block_caller !== e.block_caller)
                    report("block_caller", 32'(block_caller), 32'(e.block_caller));
                if (e.status == pim_pkg::ST_QUEUED) queued_seen++;
                if (e.wake_valid) wakes_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // called at a rising edge; returns at the edge that takes the beat
    task automatic issue(req_t r, logic typed, logic [3:0] st);
        res_t o;
        if (!no_idle && $urandom_range(99) < 34)
        begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        kind <= r.kind;
        mutex_ref <= r.mutex_ref;
        task_req <= r.task_req;
        task_valid <= r.task_valid;
        task_priority <= r.task_priority;
        may_wait <= r.may_wait;
        in_isr <= r.in_isr;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        o = apply_request(r);
        if (typed)
            o.status = st;
        outcome_q.push_back(o);
        items_sent++;
    endtask

    task automatic write_ready(logic v);
        start <= 1'b0;
        @(posedge clk);
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (LAT) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ready_reg = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic req_t mk(logic [2:0] k, logic [31:0] id, logic [3:0] t, logic tv,
                                logic [7:0] p, logic mw, logic isr);
        req_t r;
        r = '{k, id, t, tv, p, mw, isr};
        return r;
    endfunction

    function automatic logic [31:0] pick_id();
        int s;
        int c;
        c = $urandom_range(99);
        if (c < 8)
            return 32'd0;
        if (c < 22)
            return $urandom();
        s = $urandom_range(NM - 1);
        if (mtx_id[s] == 32'd0)
            return $urandom_range(8, 1);
        return mtx_id[s];
    endfunction

    function automatic req_t random_request();
        req_t r;
        int c;
        int s;
        r.mutex_ref = pick_id();
        r.task_req = 4'($urandom_range(NT - 1));
        r.task_valid = $urandom_range(99) < 92;
        r.task_priority = 8'($urandom_range(255));
        r.may_wait = $urandom_range(99) < 75;
        r.in_isr = $urandom_range(99) < 6;
        c = $urandom_range(99);
        if (c < 12) r.kind = pim_pkg::KIND_CREATE;
        else if (c < 19) r.kind = pim_pkg::KIND_DELETE;
        else if (c < 55) r.kind = pim_pkg::KIND_LOCK;
        else if (c < 87) r.kind = pim_pkg::KIND_UNLOCK;
        else if (c < 96) r.kind = pim_pkg::KIND_QUERY;
        else r.kind = 3'($urandom_range(KIND_BAD_HI, KIND_BAD_LO));
        s = slot_of(r.mutex_ref);
        if (r.kind == pim_pkg::KIND_UNLOCK && s >= 0 && mtx_locked[s]
            && $urandom_range(99) < 70)
            r.task_req = mtx_owner[s];
        return r;
    endfunction

    row_t table_rows[$];

    initial
    begin
        req_t r;
        logic [3:0] owner_t;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        kind = '0;
        mutex_ref = '0;
        task_req = '0;
        task_valid = 1'b0;
        task_priority = '0;
        may_wait = 1'b0;
        in_isr = 1'b0;
        items_sent = 0;
        no_idle = 1'b0;
        for (int i = 0; i < NM; i++)
            free_slot(i);
        for (int i = 0; i < NT; i++)
            prio_tab[i] = '0;
        id_ctr = '0;
        ready_reg = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // create refused while the kernel is not ready
        issue(mk(pim_pkg::KIND_CREATE, 0, 0, 1, 8'd0, 0, 0), 1'b1, pim_pkg::ST_UNAVAIL);
        write_ready(1'b1);

        table_rows = '{
            '{mk(pim_pkg::KIND_CREATE, 0, 4'd0, 0, 8'd0, 0, 0), 1'b1, pim_pkg::ST_OK},
            '{mk(pim_pkg::KIND_LOCK, 1, 4'd1, 1, 8'd10, 0, 0), 1'b1, pim_pkg::ST_OK},
            '{mk(pim_pkg::KIND_LOCK, 1, 4'd1, 1, 8'd10, 0, 0), 1'b1, pim_pkg::ST_OK},
            '{mk(pim_pkg::KIND_LOCK, 1, 4'd1, 1, 8'd10, 1, 1), 1'b1, pim_pkg::ST_ISR},
            '{mk(pim_pkg::KIND_LOCK, 0, 4'd1, 1, 8'd10, 1, 0), 1'b1, pim_pkg::ST_UNAVAIL},
            '{mk(pim_pkg::KIND_LOCK, 1, 4'd2, 1, 8'd200, 0, 0), 1'b1,
              pim_pkg::ST_WOULD_BLOCK},
            '{mk(pim_pkg::KIND_LOCK, 1, 4'd15, 1, 8'd255, 1, 0), 1'b0, pim_pkg::ST_OK},
            '{mk(pim_pkg::KIND_LOCK, 1, 4'd3, 0, 8'd50, 1, 0), 1'b1, pim_pkg::ST_UNAVAIL},
            '{mk(pim_pkg::KIND_UNLOCK, 1, 4'd15, 1, 8'd255, 0, 0), 1'b1,
              pim_pkg::ST_NOT_OWNER},
            '{mk(pim_pkg::KIND_UNLOCK, 1, 4'd1, 0, 8'd0, 0, 0), 1'b1, pim_pkg::ST_NOT_OWNER},
            '{mk(pim_pkg::KIND_UNLOCK, 1, 4'd1, 1, 8'd255, 0, 0), 1'b0, pim_pkg::ST_OK},
            '{mk(pim_pkg::KIND_UNLOCK, 1, 4'd1, 1, 8'd255, 0, 0), 1'b0, pim_pkg::ST_OK},
            '{mk(pim_pkg::KIND_QUERY, 1, 4'd0, 0, 8'd0, 0, 0), 1'b0, pim_pkg::ST_OK},
            '{mk(pim_pkg::KIND_QUERY, 32'hFFFF_FFFF, 4'd0, 0, 8'd0, 0, 0), 1'b0,
              pim_pkg::ST_OK},
            '{mk(KIND_BAD_LO, 1, 4'd0, 1, 8'd7, 1, 1), 1'b1, pim_pkg::ST_UNAVAIL},
            '{mk(KIND_BAD_HI, 1, 4'd0, 1, 8'd7, 1, 1), 1'b1, pim_pkg::ST_UNAVAIL},
            '{mk(pim_pkg::KIND_DELETE, 32'hFFFF_FFFF, 4'd0, 0, 8'd0, 0, 0), 1'b1,
              pim_pkg::ST_UNAVAIL},
            '{mk(pim_pkg::KIND_DELETE, 1, 4'd0, 0, 8'd0, 0, 0), 1'b1, pim_pkg::ST_OK},
            '{mk(pim_pkg::KIND_UNLOCK, 1, 4'd15, 1, 8'd0, 0, 0), 1'b1, pim_pkg::ST_UNAVAIL}
        };
        foreach (table_rows[i])
            issue(table_rows[i].rq, table_rows[i].typed, table_rows[i].st);

        // fill the table until no slot is left
        for (int i = 0; i <= NM; i++)
            issue(mk(pim_pkg::KIND_CREATE, 0, 4'd0, 0, 8'd0, 0, 0), i == NM,
                  pim_pkg::ST_NO_SLOT);

        // recursion counter to its limit, then the wait queue past its limit
        owner_t = 4'd4;
        for (int i = 0; i < 257; i++)
            issue(mk(pim_pkg::KIND_LOCK, mtx_id[0], owner_t, 1, 8'd20, 0, 0), 1'b0,
                  pim_pkg::ST_OK);
        for (int i = 0; i <= WD + 1; i++)
            issue(mk(pim_pkg::KIND_LOCK, mtx_id[0], 4'(i), 1, 8'($urandom_range(255)), 1, 0),
                  1'b0, pim_pkg::ST_OK);
        for (int i = 0; i < 260; i++)
            issue(mk(pim_pkg::KIND_UNLOCK, mtx_id[0], mtx_owner[0], 1, 8'd30, 0, 0), 1'b0,
                  pim_pkg::ST_OK);

        for (int phase = 0; phase < 3; phase++)
        begin
            write_ready(phase != 1);
            for (int n = 0; n < 62; n++)
            begin
                no_idle = (phase == 2) && (n < 40);
                issue(random_request(), 1'b0, pim_pkg::ST_OK);
            end
        end
        no_idle = 1'b0;

        start <= 1'b0;
        @(posedge clk);
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (LAT) @(posedge clk);

        $display("sent %0d requests, checked %0d results", items_sent, results_seen);
        $display("%0d callers queued, %0d hand-overs to waiters", queued_seen, wakes_seen);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
